// ===== rtl/msie_pkg.sv =====
`default_nettype none

package msie_pkg;

    // Instruction word layout
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned REG_W   = 5;
    localparam int unsigned NUM_REG = 32;

    // Major opcodes
    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_ANDI    = 6'd12;

    // Function codes under the special opcode
    localparam logic [5:0] FN_SLL = 6'd0;
    localparam logic [5:0] FN_SRL = 6'd2;
    localparam logic [5:0] FN_ADD = 6'd32;

    // Configuration space
    localparam int unsigned PADDR_W              = 3;
    localparam logic [0:0]  REG_TEXT_BASE        = 1'b0;
    localparam logic [31:0] TEXT_BASE_RESET      = 32'h0040_0000;

    // Word index of the pc relative to text_base
    typedef logic [WORD_W-3:0] word_idx_t;

endpackage : msie_pkg

`default_nettype wire

// ===== rtl/mips_subset_instruction_execute.sv =====
`default_nettype none

// Execute step of a small MIPS32 integer subset (add, sll, srl, addi, andi,
// beq, bne) on a 32-entry register file. The user fetches the word at the
// reported next_pc and offers it as an item; one item is accepted every
// cycle unless in_stall holds it while a stalled result blocks the staged
// word. The word is registered into the input stage together with the rs/rt
// register-file reads (with bypass from the instruction being executed),
// then executed and loaded into the result register. An all-zero word, or a
// pc whose word index from text_base reaches PROG_WORDS, halts the block;
// later items are still taken and answered with the held pc and halted set.
// Writing text_base over the APB port reloads the pc and leaves the register
// file and halt state alone. No clearing pass is needed after reset.
module mips_subset_instruction_execute
    import msie_pkg::*;
#(
    parameter int unsigned PROG_WORDS = 256
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    // Configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,

    // Instruction items
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [WORD_W-1:0]   instruction,

    // Result items
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [WORD_W-1:0]   next_pc,
    output logic                     reg_write,
    output logic      [REG_W-1:0]    reg_index,
    output logic      [WORD_W-1:0]   reg_value,
    output logic                     branch_taken,
    output logic                     halted
);

    // Architectural state
    logic [WORD_W-1:0]  text_base_reg;
    logic [WORD_W-1:0]  pc_reg;
    word_idx_t          pc_off_reg;
    logic               stopped_reg;
    logic [NUM_REG-1:0] rf_valid_reg;
    logic [WORD_W-1:0]  rf_mem [NUM_REG];

    // Input stage
    logic               stage_valid_reg;
    logic [WORD_W-1:0]  instr_reg;
    logic [WORD_W-1:0]  rs_data_reg;
    logic [WORD_W-1:0]  rt_data_reg;

    // Result register
    logic               out_valid_reg;
    logic [WORD_W-1:0]  out_pc_reg;
    logic               out_wr_reg;
    logic [REG_W-1:0]   out_idx_reg;
    logic [WORD_W-1:0]  out_val_reg;
    logic               out_taken_reg;
    logic               out_halted_reg;

    logic cfg_write;
    logic in_accept;
    logic exec_fire;

    // Execute results
    logic [WORD_W-1:0]  pc_next;
    word_idx_t          pc_off_next;
    logic               stopped_next;
    logic               exec_wr;
    logic [REG_W-1:0]   exec_idx;
    logic [WORD_W-1:0]  exec_val;
    logic               exec_taken;
    logic               exec_halt;

    // Decoded fields of the staged word
    logic [5:0]         op;
    logic [5:0]         fn;
    logic [REG_W-1:0]   rt_f;
    logic [REG_W-1:0]   rd_f;
    logic [REG_W-1:0]   sh_f;
    logic [15:0]        imm;
    logic [REG_W-1:0]   rs_in;
    logic [REG_W-1:0]   rt_in;

    assign op    = instr_reg[31:26];
    assign rt_f  = instr_reg[20:16];
    assign rd_f  = instr_reg[15:11];
    assign sh_f  = instr_reg[10:6];
    assign fn    = instr_reg[5:0];
    assign imm   = instr_reg[15:0];
    assign rs_in = instruction[25:21];
    assign rt_in = instruction[20:16];

    // APB access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TEXT_BASE);
    assign prdata    = (paddr[2] == REG_TEXT_BASE) ? text_base_reg : 32'd0;

    // Handshake
    assign exec_fire = stage_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = stage_valid_reg && !exec_fire;
    assign in_accept = in_valid && !in_stall;

    // Execute the staged instruction
    always_comb
    begin
        logic [WORD_W-1:0] pc_plus4;
        logic              wr;
        logic [REG_W-1:0]  idx;
        logic [WORD_W-1:0] val;
        logic              eq;

        pc_plus4     = pc_reg + 32'd4;
        wr           = 1'b0;
        idx          = rd_f;
        val          = '0;
        eq           = (rs_data_reg == rt_data_reg);
        exec_taken   = 1'b0;
        pc_next      = pc_plus4;
        pc_off_next  = pc_off_reg + word_idx_t'(1);

        unique case (op)
            OP_SPECIAL:
            begin
                unique case (fn)
                    FN_ADD:
                    begin
                        wr  = 1'b1;
                        val = rs_data_reg + rt_data_reg;
                    end
                    FN_SLL:
                    begin
                        wr  = 1'b1;
                        val = rt_data_reg << sh_f;
                    end
                    FN_SRL:
                    begin
                        wr  = 1'b1;
                        val = rt_data_reg >> sh_f;
                    end
                    default: ;
                endcase
            end
            OP_ADDI:
            begin
                wr  = 1'b1;
                idx = rt_f;
                val = rs_data_reg + {{16{imm[15]}}, imm};
            end
            OP_ANDI:
            begin
                wr  = 1'b1;
                idx = rt_f;
                val = rs_data_reg & {16'd0, imm};
            end
            OP_BEQ, OP_BNE:
            begin
                exec_taken = (op == OP_BEQ) ? eq : !eq;
                if (exec_taken)
                begin
                    pc_next     = pc_plus4 + {{14{imm[15]}}, imm, 2'b00};
                    pc_off_next = pc_off_reg + word_idx_t'(1) + {{14{imm[15]}}, imm};
                end
            end
            default: ;
        endcase

        // Zero word or already halted: nothing moves
        exec_halt = stopped_reg || (instr_reg == '0);
        if (exec_halt)
        begin
            exec_wr      = 1'b0;
            exec_idx     = '0;
            exec_val     = '0;
            exec_taken   = 1'b0;
            pc_next      = pc_reg;
            pc_off_next  = pc_off_reg;
            stopped_next = 1'b1;
        end
        else
        begin
            exec_wr      = wr && (idx != '0);
            exec_idx     = exec_wr ? idx : '0;
            exec_val     = exec_wr ? val : '0;
            stopped_next = (pc_off_next >= word_idx_t'(PROG_WORDS));
        end
    end

    // Configuration and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_base_reg <= TEXT_BASE_RESET;
            pc_reg        <= TEXT_BASE_RESET;
            pc_off_reg    <= '0;
            stopped_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            text_base_reg <= pwdata;
            pc_reg        <= pwdata;
            pc_off_reg    <= '0;
        end
        else if (exec_fire)
        begin
            pc_reg      <= pc_next;
            pc_off_reg  <= pc_off_next;
            stopped_reg <= stopped_next;
        end
    end

    // Register-file valid bits: an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
        end
        else if (exec_fire && exec_wr)
        begin
            rf_valid_reg[exec_idx] <= 1'b1;
        end
    end

    // Register-file storage and registered reads with bypass
    always_ff @(posedge clk)
    begin
        if (exec_fire && exec_wr)
        begin
            rf_mem[exec_idx] <= exec_val;
        end
        if (in_accept)
        begin
            instr_reg <= instruction;
            if (exec_fire && exec_wr && (exec_idx == rs_in))
                rs_data_reg <= exec_val;
            else if (!rf_valid_reg[rs_in])
                rs_data_reg <= '0;
            else
                rs_data_reg <= rf_mem[rs_in];
            if (exec_fire && exec_wr && (exec_idx == rt_in))
                rt_data_reg <= exec_val;
            else if (!rf_valid_reg[rt_in])
                rt_data_reg <= '0;
            else
                rt_data_reg <= rf_mem[rt_in];
        end
    end

    // Stage and result valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
                stage_valid_reg <= 1'b1;
            else if (exec_fire)
                stage_valid_reg <= 1'b0;

            if (exec_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            out_pc_reg     <= pc_next;
            out_wr_reg     <= exec_wr;
            out_idx_reg    <= exec_idx;
            out_val_reg    <= exec_val;
            out_taken_reg  <= exec_taken;
            out_halted_reg <= stopped_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_pc      = out_pc_reg;
    assign reg_write    = out_wr_reg;
    assign reg_index    = out_idx_reg;
    assign reg_value    = out_val_reg;
    assign branch_taken = out_taken_reg;
    assign halted       = out_halted_reg;

    // Register zero is never marked as written
    a_rf_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !rf_valid_reg[0])
        else $error("register zero marked valid");

    // Halt is sticky: rewriting text_base does not clear it, only reset does
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg && !cfg_write |=> stopped_reg)
        else $error("halt state cleared");

    // A halted block holds its pc
    a_halt_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && stopped_reg && !cfg_write |=> $stable(pc_reg))
        else $error("pc moved while halted");

    // The word offset tracks pc relative to text_base
    a_pc_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg - text_base_reg) == {pc_off_reg, 2'b00})
        else $error("pc offset out of step");

endmodule : mips_subset_instruction_execute

`default_nettype wire
